// ----- rtl/ttrr_pkg.sv -----
// ============================================================================
// ttrr_pkg - shared types and constants for the task table scheduler
// Mode, status and slot state codes, table port structs, result struct and
// the controller state type.
// ============================================================================
package ttrr_pkg;

    // Default number of task slots
    localparam int TASKS_DEFAULT = 16;

    // Field widths
    localparam int MODE_W = 2;
    localparam int TID_W  = 6;
    localparam int CODE_W = 32;
    localparam int STAT_W = 2;
    localparam int LIVE_W = 7;
    localparam int IN_W   = 40;
    localparam int OUT_W  = 56;

    // Operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE = 2'd0,
        MODE_EXIT   = 2'd1,
        MODE_WAIT   = 2'd2,
        MODE_SCHED  = 2'd3
    } mode_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_SLOT  = 2'd1,
        STAT_NO_CHILD = 2'd2
    } status_t;

    // Slot states
    typedef enum logic [2:0] {
        SLOT_UNUSED  = 3'd0,
        SLOT_READY   = 3'd1,
        SLOT_RUNNING = 3'd2,
        SLOT_ZOMBIE  = 3'd4,
        SLOT_WAITING = 3'd5
    } slot_state_t;

    // Table write command
    typedef struct packed {
        logic               st_en;
        logic               par_en;
        logic [TID_W-1:0]   addr;
        slot_state_t        st;
        logic [TID_W-1:0]   parent;
    } tbl_wr_t;

    // Table read data
    typedef struct packed {
        slot_state_t        st;
        logic [TID_W-1:0]   parent;
    } tbl_rd_t;

    // One result item
    typedef struct packed {
        logic [LIVE_W-1:0]  live_count;
        logic [TID_W-1:0]   running_task;
        logic [CODE_W-1:0]  reaped_code;
        logic [TID_W-1:0]   result_task;
        status_t            status;
    } result_t;

    // Controller states
    typedef enum logic [4:0] {
        CS_IDLE,
        CS_SCAN,
        CS_C_WR,
        CS_E_RDCUR,
        CS_E_CHKCUR,
        CS_E_CHKPAR,
        CS_E_WR,
        CS_W_RDTID,
        CS_W_CHK,
        CS_REAP,
        CS_REAP_CODE,
        CS_S_RDCUR,
        CS_S_RD0,
        CS_S_CHK0,
        CS_SW_OLD,
        CS_SW_NEW,
        CS_OUT
    } ctrl_state_t;

endpackage

// ----- rtl/ttrr_table.sv -----
// ============================================================================
// ttrr_table - slot state and parent memory
// One write port with separate field enables, one registered read port.
// Valid bits stand in for the reset contents.
// ============================================================================
module ttrr_table #(
    parameter int TASKS = ttrr_pkg::TASKS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(TASKS)-1:0]       rd_addr,
    input  ttrr_pkg::tbl_wr_t              wr,
    output ttrr_pkg::tbl_rd_t              rd
);

    localparam int IW = $clog2(TASKS);

    ttrr_pkg::slot_state_t st_mem  [TASKS];
    logic [IW-1:0]         par_mem [TASKS];
    logic [TASKS-1:0]      vld_reg;

    ttrr_pkg::slot_state_t st_q;
    logic [IW-1:0]         par_q;
    logic                  vld_q;
    logic                  zero_q;
    logic [IW-1:0]         wa;

    assign wa = wr.addr[IW-1:0];

    // Valid bits: an entry never written reads as its reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.st_en)
        begin
            vld_reg[wa] <= 1'b1;
        end
    end

    // Storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.st_en)
        begin
            st_mem[wa] <= wr.st;
        end
        // first write of an entry without a parent write also sets its parent to the reset value
        if (wr.par_en || (wr.st_en && !vld_reg[wa]))
        begin
            par_mem[wa] <= wr.par_en ? wr.parent[IW-1:0] : '0;
        end
        st_q   <= st_mem[rd_addr];
        par_q  <= par_mem[rd_addr];
        vld_q  <= vld_reg[rd_addr];
        zero_q <= (rd_addr == '0);
    end

    // Reset value substitution: slot 0 running, others unused, parent zero
    always_comb
    begin
        if (vld_q)
        begin
            rd.st     = st_q;
            rd.parent = ttrr_pkg::TID_W'(par_q);
        end
        else
        begin
            rd.st     = zero_q ? ttrr_pkg::SLOT_RUNNING : ttrr_pkg::SLOT_UNUSED;
            rd.parent = '0;
        end
    end

endmodule

// ----- rtl/ttrr_code_ram.sv -----
// ============================================================================
// ttrr_code_ram - exit code memory
// Simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
module ttrr_code_ram #(
    parameter int TASKS = ttrr_pkg::TASKS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(TASKS)-1:0]          waddr,
    input  logic [ttrr_pkg::CODE_W-1:0]       wdata,
    input  logic [$clog2(TASKS)-1:0]          raddr,
    output logic [ttrr_pkg::CODE_W-1:0]       rdata
);

    logic [ttrr_pkg::CODE_W-1:0] mem [TASKS];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/ttrr_ctrl.sv -----
// ============================================================================
// ttrr_ctrl - operation sequencer
// Walks the slot table one read per cycle, decides each operation and
// writes the changed entries back.
// ============================================================================
module ttrr_ctrl #(
    parameter int TASKS = ttrr_pkg::TASKS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request side
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ttrr_pkg::mode_t                   in_mode,
    input  logic [ttrr_pkg::TID_W-1:0]        in_tid,
    input  logic [ttrr_pkg::CODE_W-1:0]       in_code,
    // result side
    output logic                              res_valid,
    input  logic                              res_ready,
    output ttrr_pkg::result_t                 res,
    // slot table
    output logic [$clog2(TASKS)-1:0]          rd_addr,
    output ttrr_pkg::tbl_wr_t                 tbl_wr,
    input  ttrr_pkg::tbl_rd_t                 rd,
    // exit code memory
    output logic                              code_we,
    output logic [$clog2(TASKS)-1:0]          code_waddr,
    output logic [ttrr_pkg::CODE_W-1:0]       code_wdata,
    output logic [$clog2(TASKS)-1:0]          code_raddr,
    input  logic [ttrr_pkg::CODE_W-1:0]       code_rdata
);

    localparam int IW = $clog2(TASKS);
    localparam int CW = $clog2(TASKS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TASKS - 1);
    localparam logic [CW-1:0] N_ALL    = CW'(TASKS);
    localparam logic [CW-1:0] N_SUB    = CW'(TASKS - 1);
    localparam logic [ttrr_pkg::TID_W:0] TASKS_W = (ttrr_pkg::TID_W + 1)'(TASKS);

    typedef enum logic [1:0] {
        SCAN_FREE,
        SCAN_CHILD,
        SCAN_RUN
    } scan_kind_t;

    ttrr_pkg::ctrl_state_t state_reg, state_next;
    logic [IW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            rv_reg, rv_next;
    logic            rlast_reg, rlast_next;
    logic [IW-1:0]   rtag_reg, rtag_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   iss_reg, iss_next;
    scan_kind_t      kind_reg, kind_next;
    logic [IW-1:0]   target_reg, target_next;
    logic            freed_reg, freed_next;
    logic            cur_run_reg, cur_run_next;
    logic [ttrr_pkg::TID_W-1:0]  tid_reg, tid_next;
    logic [ttrr_pkg::CODE_W-1:0] code_reg, code_next;
    ttrr_pkg::status_t           status_reg, status_next;
    logic [IW-1:0]               result_reg, result_next;
    logic [ttrr_pkg::CODE_W-1:0] reaped_reg, reaped_next;

    logic            accept;
    logic            tid_big;
    logic [CW-1:0]   scan_n;
    logic [IW-1:0]   scan_addr;
    logic            scan_issue;
    logic            hit;
    logic            scan_found;
    logic            scan_none;
    logic            par_is_cur;
    logic [IW-1:0]   cur_succ;

    // Shared decode
    assign accept     = in_valid && (state_reg == ttrr_pkg::CS_IDLE);
    assign tid_big    = {1'b0, in_tid} >= TASKS_W;
    assign scan_n     = (kind_reg == SCAN_RUN) ? N_ALL : N_SUB;
    assign scan_addr  = (idx_reg == '0) ? IW'(1) : idx_reg;
    assign scan_issue = (state_reg == ttrr_pkg::CS_SCAN) && (iss_reg != scan_n);
    assign par_is_cur = (rd.parent == ttrr_pkg::TID_W'(cur_reg));
    assign cur_succ   = (cur_reg == LAST_IDX) ? '0 : cur_reg + IW'(1);

    // Scan predicate on the entry read last cycle
    always_comb
    begin
        case (kind_reg)
            SCAN_FREE:  hit = (rd.st == ttrr_pkg::SLOT_UNUSED);
            SCAN_CHILD: hit = par_is_cur && (rd.st == ttrr_pkg::SLOT_ZOMBIE);
            SCAN_RUN:   hit = (rd.st == ttrr_pkg::SLOT_READY) ||
                              (rd.st == ttrr_pkg::SLOT_RUNNING);
            default:    hit = 1'b0;
        endcase
    end

    assign scan_found = rv_reg && hit;
    assign scan_none  = rv_reg && !hit && rlast_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttrr_pkg::CS_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_mode)
                        ttrr_pkg::MODE_CREATE: state_next = ttrr_pkg::CS_SCAN;
                        ttrr_pkg::MODE_EXIT:   state_next = ttrr_pkg::CS_E_RDCUR;
                        ttrr_pkg::MODE_WAIT:
                        begin
                            if (in_tid == '0)
                                state_next = ttrr_pkg::CS_SCAN;
                            else if (tid_big)
                                state_next = ttrr_pkg::CS_OUT;
                            else
                                state_next = ttrr_pkg::CS_W_RDTID;
                        end
                        default:               state_next = ttrr_pkg::CS_S_RDCUR;
                    endcase
                end
            end
            ttrr_pkg::CS_SCAN:
            begin
                if (scan_found)
                begin
                    case (kind_reg)
                        SCAN_FREE:  state_next = ttrr_pkg::CS_C_WR;
                        SCAN_CHILD: state_next = ttrr_pkg::CS_REAP;
                        default:    state_next = (rtag_reg != cur_reg) ?
                                                 ttrr_pkg::CS_SW_OLD : ttrr_pkg::CS_OUT;
                    endcase
                end
                else if (scan_none)
                begin
                    if (kind_reg == SCAN_RUN && cur_reg != '0)
                        state_next = ttrr_pkg::CS_S_RD0;
                    else
                        state_next = ttrr_pkg::CS_OUT;
                end
            end
            ttrr_pkg::CS_C_WR:      state_next = ttrr_pkg::CS_OUT;
            ttrr_pkg::CS_E_RDCUR:   state_next = ttrr_pkg::CS_E_CHKCUR;
            ttrr_pkg::CS_E_CHKCUR:
            begin
                if (rd.st == ttrr_pkg::SLOT_UNUSED)
                    state_next = ttrr_pkg::CS_S_RDCUR;
                else if (rd.parent == '0 || par_is_cur)
                    state_next = ttrr_pkg::CS_E_WR;
                else
                    state_next = ttrr_pkg::CS_E_CHKPAR;
            end
            ttrr_pkg::CS_E_CHKPAR:  state_next = ttrr_pkg::CS_E_WR;
            ttrr_pkg::CS_E_WR:      state_next = ttrr_pkg::CS_S_RDCUR;
            ttrr_pkg::CS_W_RDTID:   state_next = ttrr_pkg::CS_W_CHK;
            ttrr_pkg::CS_W_CHK:
            begin
                if (!par_is_cur)
                    state_next = ttrr_pkg::CS_OUT;
                else if (rd.st == ttrr_pkg::SLOT_ZOMBIE)
                    state_next = ttrr_pkg::CS_REAP;
                else
                    state_next = ttrr_pkg::CS_S_RDCUR;
            end
            ttrr_pkg::CS_REAP:      state_next = ttrr_pkg::CS_REAP_CODE;
            ttrr_pkg::CS_REAP_CODE: state_next = ttrr_pkg::CS_OUT;
            ttrr_pkg::CS_S_RDCUR:   state_next = ttrr_pkg::CS_SCAN;
            ttrr_pkg::CS_S_RD0:     state_next = ttrr_pkg::CS_S_CHK0;
            ttrr_pkg::CS_S_CHK0:
            begin
                if (rd.st == ttrr_pkg::SLOT_UNUSED)
                    state_next = ttrr_pkg::CS_OUT;
                else
                    state_next = ttrr_pkg::CS_SW_OLD;
            end
            ttrr_pkg::CS_SW_OLD:    state_next = ttrr_pkg::CS_SW_NEW;
            ttrr_pkg::CS_SW_NEW:    state_next = ttrr_pkg::CS_OUT;
            ttrr_pkg::CS_OUT:
            begin
                if (res_ready)
                    state_next = ttrr_pkg::CS_IDLE;
            end
            default:                state_next = ttrr_pkg::CS_IDLE;
        endcase
    end

    // Outputs: handshakes and memory commands
    always_comb
    begin
        in_ready      = (state_reg == ttrr_pkg::CS_IDLE);
        res_valid     = (state_reg == ttrr_pkg::CS_OUT);
        rd_addr       = scan_addr;
        tbl_wr.st_en  = 1'b0;
        tbl_wr.par_en = 1'b0;
        tbl_wr.addr   = ttrr_pkg::TID_W'(cur_reg);
        tbl_wr.st     = ttrr_pkg::SLOT_UNUSED;
        tbl_wr.parent = ttrr_pkg::TID_W'(cur_reg);
        code_we       = 1'b0;
        code_waddr    = cur_reg;
        code_wdata    = code_reg;
        code_raddr    = target_reg;
        case (state_reg)
            ttrr_pkg::CS_E_RDCUR,
            ttrr_pkg::CS_S_RDCUR:  rd_addr = cur_reg;
            ttrr_pkg::CS_E_CHKCUR: rd_addr = rd.parent[IW-1:0];
            ttrr_pkg::CS_W_RDTID:  rd_addr = tid_reg[IW-1:0];
            ttrr_pkg::CS_S_RD0:    rd_addr = '0;
            ttrr_pkg::CS_C_WR:
            begin
                tbl_wr.st_en  = 1'b1;
                tbl_wr.par_en = 1'b1;
                tbl_wr.addr   = ttrr_pkg::TID_W'(target_reg);
                tbl_wr.st     = ttrr_pkg::SLOT_READY;
            end
            ttrr_pkg::CS_E_WR:
            begin
                tbl_wr.st_en = 1'b1;
                tbl_wr.st    = freed_reg ? ttrr_pkg::SLOT_UNUSED : ttrr_pkg::SLOT_ZOMBIE;
                code_we      = 1'b1;
            end
            ttrr_pkg::CS_W_CHK:
            begin
                // caller blocks on a live child
                if (par_is_cur && rd.st != ttrr_pkg::SLOT_ZOMBIE)
                begin
                    tbl_wr.st_en = 1'b1;
                    tbl_wr.st    = ttrr_pkg::SLOT_WAITING;
                end
            end
            ttrr_pkg::CS_REAP:
            begin
                tbl_wr.st_en = 1'b1;
                tbl_wr.addr  = ttrr_pkg::TID_W'(target_reg);
                tbl_wr.st    = ttrr_pkg::SLOT_UNUSED;
            end
            ttrr_pkg::CS_SW_OLD:
            begin
                tbl_wr.st_en = cur_run_reg;
                tbl_wr.st    = ttrr_pkg::SLOT_READY;
            end
            ttrr_pkg::CS_SW_NEW:
            begin
                tbl_wr.st_en = 1'b1;
                tbl_wr.addr  = ttrr_pkg::TID_W'(target_reg);
                tbl_wr.st    = ttrr_pkg::SLOT_RUNNING;
            end
            default:
            begin
                rd_addr = scan_addr;
            end
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        cur_next     = cur_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        iss_next     = iss_reg;
        kind_next    = kind_reg;
        target_next  = target_reg;
        freed_next   = freed_reg;
        cur_run_next = cur_run_reg;
        tid_next     = tid_reg;
        code_next    = code_reg;
        status_next  = status_reg;
        result_next  = result_reg;
        reaped_next  = reaped_reg;
        rv_next      = scan_issue;
        rlast_next   = (iss_reg == scan_n - CW'(1));
        rtag_next    = scan_addr;
        case (state_reg)
            ttrr_pkg::CS_IDLE:
            begin
                if (accept)
                begin
                    tid_next    = in_tid;
                    code_next   = in_code;
                    status_next = ttrr_pkg::STAT_OK;
                    result_next = '0;
                    reaped_next = '0;
                    idx_next    = IW'(1);
                    iss_next    = '0;
                    kind_next   = (in_mode == ttrr_pkg::MODE_CREATE) ? SCAN_FREE : SCAN_CHILD;
                    if (in_mode == ttrr_pkg::MODE_WAIT && in_tid != '0 && tid_big)
                        status_next = ttrr_pkg::STAT_NO_CHILD;
                end
            end
            ttrr_pkg::CS_SCAN:
            begin
                if (scan_issue)
                begin
                    idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + IW'(1);
                    iss_next = iss_reg + CW'(1);
                end
                // first cycle of a schedule walk carries the current slot
                if (iss_reg == '0)
                    cur_run_next = (rd.st == ttrr_pkg::SLOT_RUNNING);
                if (scan_found)
                    target_next = rtag_reg;
                else if (scan_none)
                begin
                    case (kind_reg)
                        SCAN_FREE:  status_next = ttrr_pkg::STAT_NO_SLOT;
                        SCAN_CHILD: status_next = ttrr_pkg::STAT_NO_CHILD;
                        default:    target_next = '0;
                    endcase
                end
            end
            ttrr_pkg::CS_C_WR:
            begin
                count_next  = count_reg + CW'(1);
                result_next = target_reg;
            end
            ttrr_pkg::CS_E_CHKCUR:
            begin
                freed_next = (rd.parent == '0);
            end
            ttrr_pkg::CS_E_CHKPAR:
            begin
                freed_next = (rd.st == ttrr_pkg::SLOT_UNUSED);
            end
            ttrr_pkg::CS_E_WR:
            begin
                if (freed_reg)
                    count_next = count_reg - CW'(1);
            end
            ttrr_pkg::CS_W_CHK:
            begin
                target_next = tid_reg[IW-1:0];
                if (!par_is_cur || rd.st != ttrr_pkg::SLOT_ZOMBIE)
                    status_next = ttrr_pkg::STAT_NO_CHILD;
            end
            ttrr_pkg::CS_REAP:
            begin
                count_next  = count_reg - CW'(1);
                result_next = target_reg;
            end
            ttrr_pkg::CS_REAP_CODE:
            begin
                reaped_next = code_rdata;
            end
            ttrr_pkg::CS_S_RDCUR:
            begin
                kind_next = SCAN_RUN;
                idx_next  = cur_succ;
                iss_next  = '0;
            end
            ttrr_pkg::CS_S_CHK0:
            begin
                target_next = '0;
            end
            ttrr_pkg::CS_SW_NEW:
            begin
                cur_next = target_reg;
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttrr_pkg::CS_IDLE;
            cur_reg   <= '0;
            count_reg <= CW'(1);
            rv_reg    <= 1'b0;
            rlast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
            rlast_reg <= rlast_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rtag_reg    <= rtag_next;
        idx_reg     <= idx_next;
        iss_reg     <= iss_next;
        kind_reg    <= kind_next;
        target_reg  <= target_next;
        freed_reg   <= freed_next;
        cur_run_reg <= cur_run_next;
        tid_reg     <= tid_next;
        code_reg    <= code_next;
        status_reg  <= status_next;
        result_reg  <= result_next;
        reaped_reg  <= reaped_next;
    end

    // Result item
    assign res.status       = status_reg;
    assign res.result_task  = ttrr_pkg::TID_W'(result_reg);
    assign res.reaped_code  = reaped_reg;
    assign res.running_task = ttrr_pkg::TID_W'(cur_reg);
    assign res.live_count   = ttrr_pkg::LIVE_W'(count_reg);

endmodule

// ----- rtl/task_table_round_robin_scheduler.sv -----
// ============================================================================
// task_table_round_robin_scheduler - task table with round-robin scheduling
// Top level: request and result streams, slot memories, sequencer and the
// result output register.
// ============================================================================
// Usage:
// Requests enter on the s_axis group, one operation per transfer (create,
// exit, wait for child, schedule). Each request yields exactly one result
// transfer on the m_axis group, in order.
// Latency from request transfer to result valid is least for a wait on a
// slot number beyond the table and greatest for an exit followed by a full
// schedule walk that ends in a switch to slot 0; a create that finds slot 1
// free ends its scan on the first entry read. The latency is set mainly by
// the walk over the slot table, which reads one entry per cycle from the
// single-read-port state memory.
// One request is in work at a time; the next is taken once the sequencer
// is back in idle, which it enters as the previous result moves into the
// output register, even if the receiver has not yet taken it.
// Reset makes slot 0 the running idle task with one slot occupied; valid
// bits supply the reset contents, so no clearing pass is needed and a
// request can be taken in the first cycle after reset.
// When the receiver stalls, the result holds in the output register and
// the sequencer waits with the next result until it drains.
// ============================================================================
module task_table_round_robin_scheduler #(
    parameter int TASKS = ttrr_pkg::TASKS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] mode, [7:2] task_id, [39:8] exit_code
    input  logic [ttrr_pkg::IN_W-1:0]     s_axis_tdata,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] status, [7:2] result_task, [39:8] reaped_code,
    // [45:40] running_task, [52:46] live_count, [55:53] zero
    output logic [ttrr_pkg::OUT_W-1:0]    m_axis_tdata
);

    localparam int IW = $clog2(TASKS);

    logic                         res_valid;
    logic                         res_ready;
    ttrr_pkg::result_t            res;
    logic [IW-1:0]                rd_addr;
    ttrr_pkg::tbl_wr_t            tbl_wr;
    ttrr_pkg::tbl_rd_t            tbl_rd;
    logic                         code_we;
    logic [IW-1:0]                code_waddr;
    logic [ttrr_pkg::CODE_W-1:0]  code_wdata;
    logic [IW-1:0]                code_raddr;
    logic [ttrr_pkg::CODE_W-1:0]  code_rdata;

    logic                         m_valid_reg;
    ttrr_pkg::result_t            m_data_reg;

    // Slot state and parent memory
    ttrr_table #(
        .TASKS (TASKS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .wr      (tbl_wr),
        .rd      (tbl_rd)
    );

    // Exit code memory
    ttrr_code_ram #(
        .TASKS (TASKS)
    ) u_code_ram (
        .clk   (clk),
        .we    (code_we),
        .waddr (code_waddr),
        .wdata (code_wdata),
        .raddr (code_raddr),
        .rdata (code_rdata)
    );

    // Operation sequencer
    ttrr_ctrl #(
        .TASKS (TASKS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_mode    (ttrr_pkg::mode_t'(s_axis_tdata[1:0])),
        .in_tid     (s_axis_tdata[7:2]),
        .in_code    (s_axis_tdata[39:8]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .rd_addr    (rd_addr),
        .tbl_wr     (tbl_wr),
        .rd         (tbl_rd),
        .code_we    (code_we),
        .code_waddr (code_waddr),
        .code_wdata (code_wdata),
        .code_raddr (code_raddr),
        .code_rdata (code_rdata)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_data_reg};

endmodule

// ----- rtl/ttrr_checker.sv -----
// ============================================================================
// ttrr_checker - port-level checks for the task table scheduler
// Watches the result stream; attached to the top level by a bind.
// ============================================================================
module ttrr_checker #(
    parameter int TASKS = ttrr_pkg::TASKS_DEFAULT
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [ttrr_pkg::IN_W-1:0]     s_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ttrr_pkg::OUT_W-1:0]    m_axis_tdata
);

    logic [1:0] status;
    logic [5:0] result_task;
    logic [31:0] reaped_code;
    logic [5:0] running_task;
    logic [7:0] live_count;
    logic [7:0] last_live_reg;
    logic       have_last_reg;
    logic       out_xfer;
    logic       in_xfer;

    assign status       = m_axis_tdata[1:0];
    assign result_task  = m_axis_tdata[7:2];
    assign reaped_code  = m_axis_tdata[39:8];
    assign running_task = m_axis_tdata[45:40];
    assign live_count   = {1'b0, m_axis_tdata[52:46]};
    assign out_xfer     = m_axis_tvalid && m_axis_tready;
    assign in_xfer      = s_axis_tvalid && s_axis_tready
                          && (s_axis_tdata[1:0] != ttrr_pkg::MODE_SCHED);

    // Occupancy of the previous delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_live_reg <= 8'd1;
            have_last_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            last_live_reg <= live_count;
            have_last_reg <= 1'b1;
        end
        else if (in_xfer)
        begin
            have_last_reg <= have_last_reg;
        end
    end

    // A stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // Slot numbers and occupancy stay within the table
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (live_count <= 8'(TASKS) && 7'(running_task) < 7'(TASKS)
                           && 7'(result_task) < 7'(TASKS)))
        else $error("slot number or occupancy out of range");

    // A failed create reports no slot and no code
    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status == ttrr_pkg::STAT_NO_SLOT) |->
        (result_task == '0 && reaped_code == '0))
        else $error("failed create carries payload");

    // Occupancy moves by at most one per operation
    a_live_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && have_last_reg) |->
        (live_count == last_live_reg || live_count == last_live_reg + 8'd1
         || live_count + 8'd1 == last_live_reg))
        else $error("occupancy jumped by more than one");

endmodule

bind task_table_round_robin_scheduler ttrr_checker #(
    .TASKS (TASKS)
) u_ttrr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
